// ----- rtl/nwp_pkg.sv -----
// Shared constants for the nearest waypoint progress block.
// Depends on nothing; imported by nearest_waypoint_progress.
package nwp_pkg;

  localparam int MAX_POINTS = 256;
  localparam int COORD_BITS = 24;

  localparam int IN_COORD_BITS = 24;
  localparam int IDX_BITS      = $clog2(MAX_POINTS);
  localparam int CNT_BITS      = $clog2(MAX_POINTS + 1);
  localparam int MAG_BITS      = COORD_BITS + 1;
  localparam int SQ_BITS       = 2 * MAG_BITS;
  localparam int DIST_BITS     = SQ_BITS + 1;
  localparam int PROG_BITS     = 16;
  localparam int DIV_CNT_BITS  = $clog2(PROG_BITS);

  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

endpackage

// ----- rtl/nwp_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module nwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/nearest_waypoint_progress.sv -----
// Nearest track point search with progress fraction.
// Depends on nwp_pkg and nwp_ram.
//
// A transaction is taken when start is high and busy is low; its result appears on the
// following cycles for exactly one cycle, marked by done, and cannot be held off.
// Clear and append finish in one cycle: done rises in the cycle after start. A query
// on a table of N points first scans the table: the point store has one read port, so
// the scan reads one point per cycle through a four-stage square-and-compare pipeline,
// and the progress fraction then comes from a restoring divider giving one bit a cycle.
// A query on an empty table answers with done in the cycle after start. busy stays
// high through a non-empty query. An append to a full table is dropped and flagged.
module nearest_waypoint_progress
  import nwp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [1:0]                  kind,
  input  logic signed [IN_COORD_BITS-1:0] pos_x,
  input  logic signed [IN_COORD_BITS-1:0] pos_y,
  output logic                        busy,
  output logic                        done,
  output logic [7:0]                  nearest_index,
  output logic [15:0]                 progress,
  output logic [8:0]                  stored_count,
  output logic                        table_empty,
  output logic                        append_rejected
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV} state_t;

  state_t state;

  logic [CNT_BITS-1:0]   point_count;
  logic [CNT_BITS-1:0]   issue_idx;
  logic [COORD_BITS-1:0] qx, qy;

  // scan pipeline
  logic                  v1, v2, v3;
  logic [IDX_BITS-1:0]   idx1, idx2, idx3;
  logic [MAG_BITS-1:0]   magx, magy;
  logic [SQ_BITS-1:0]    sqx, sqy;
  logic                  have_best;
  logic [DIST_BITS-1:0]  best_dist;
  logic [IDX_BITS-1:0]   best_idx;

  // divider
  logic [CNT_BITS-1:0]     rem;
  logic [PROG_BITS-1:0]    quo;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  logic                    accept;
  logic [COORD_BITS-1:0]   in_x, in_y;
  logic                    ram_we;
  logic [2*COORD_BITS-1:0] ram_rdata;
  logic [COORD_BITS-1:0]   sx, sy;
  logic [COORD_BITS:0]     dx, dy;
  logic [MAG_BITS-1:0]     magx_next, magy_next;
  logic [DIST_BITS-1:0]    cand_dist;
  logic                    issuing;
  logic                    scan_done;
  logic [CNT_BITS:0]       rem2;
  logic                    rem_ge;
  logic [CNT_BITS-1:0]     rem_next;
  logic [PROG_BITS-1:0]    quo_next;
  logic                    full;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign full   = (point_count == CNT_BITS'(MAX_POINTS));

  // cast the input coordinate to the stored width; the two widths are equal here
  assign in_x = COORD_BITS'(pos_x);
  assign in_y = COORD_BITS'(pos_y);

  assign ram_we  = accept && (kind == KIND_APPEND) && !full;
  assign issuing = (state == S_SCAN) && (issue_idx != point_count);

  nwp_ram #(
    .WIDTH (2 * COORD_BITS),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (point_count[IDX_BITS-1:0]),
    .wdata ({in_x, in_y}),
    .raddr (issue_idx[IDX_BITS-1:0]),
    .rdata (ram_rdata)
  );

  assign sx = ram_rdata[2*COORD_BITS-1:COORD_BITS];
  assign sy = ram_rdata[COORD_BITS-1:0];

  always_comb begin
    dx = {qx[COORD_BITS-1], qx} - {sx[COORD_BITS-1], sx};
    dy = {qy[COORD_BITS-1], qy} - {sy[COORD_BITS-1], sy};
    magx_next = dx[COORD_BITS] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    magy_next = dy[COORD_BITS] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
    cand_dist = DIST_BITS'(sqx) + DIST_BITS'(sqy);
    scan_done = (issue_idx == point_count) && !v1 && !v2 && !v3;
  end

  // restoring division step: remainder stays below the count
  always_comb begin
    rem2     = {rem, 1'b0};
    rem_ge   = (rem2 >= {1'b0, point_count});
    rem_next = rem_ge ? CNT_BITS'(rem2 - {1'b0, point_count}) : CNT_BITS'(rem2);
    quo_next = {quo[PROG_BITS-2:0], rem_ge};
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      qx <= in_x;
      qy <= in_y;
    end
    idx1 <= issue_idx[IDX_BITS-1:0];
    idx2 <= idx1;
    idx3 <= idx2;
    magx <= magx_next;
    magy <= magy_next;
    sqx  <= SQ_BITS'(magx) * SQ_BITS'(magx);
    sqy  <= SQ_BITS'(magy) * SQ_BITS'(magy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      point_count     <= '0;
      issue_idx       <= '0;
      v1              <= 1'b0;
      v2              <= 1'b0;
      v3              <= 1'b0;
      have_best       <= 1'b0;
      best_dist       <= '0;
      best_idx        <= '0;
      rem             <= '0;
      quo             <= '0;
      div_cnt         <= '0;
      done            <= 1'b0;
      nearest_index   <= '0;
      progress        <= '0;
      stored_count    <= '0;
      table_empty     <= 1'b1;
      append_rejected <= 1'b0;
    end else begin
      done <= 1'b0;
      v1   <= issuing;
      v2   <= v1;
      v3   <= v2;
      if (issuing) begin
        issue_idx <= issue_idx + 1'b1;
      end
      // strict less-than keeps the earliest point on a tie
      if (v3 && (!have_best || cand_dist < best_dist)) begin
        have_best <= 1'b1;
        best_dist <= cand_dist;
        best_idx  <= idx3;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_CLEAR: begin
                point_count     <= '0;
                done            <= 1'b1;
                nearest_index   <= '0;
                progress        <= '0;
                stored_count    <= '0;
                table_empty     <= 1'b1;
                append_rejected <= 1'b0;
              end
              KIND_APPEND: begin
                done            <= 1'b1;
                nearest_index   <= '0;
                progress        <= '0;
                append_rejected <= full;
                if (!full) begin
                  point_count  <= point_count + 1'b1;
                  stored_count <= 9'(point_count + 1'b1);
                end else begin
                  stored_count <= 9'(point_count);
                end
                table_empty <= 1'b0;
              end
              KIND_QUERY: begin
                if (point_count == '0) begin
                  done            <= 1'b1;
                  nearest_index   <= '0;
                  progress        <= '0;
                  stored_count    <= '0;
                  table_empty     <= 1'b1;
                  append_rejected <= 1'b0;
                end else begin
                  state     <= S_SCAN;
                  issue_idx <= '0;
                  have_best <= 1'b0;
                end
              end
              default: begin
                done            <= 1'b1;
                nearest_index   <= '0;
                progress        <= '0;
                stored_count    <= 9'(point_count);
                table_empty     <= (point_count == '0);
                append_rejected <= 1'b0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state   <= S_DIV;
            rem     <= CNT_BITS'(best_idx);
            quo     <= '0;
            div_cnt <= '0;
          end
        end
        S_DIV: begin
          rem     <= rem_next;
          quo     <= quo_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_BITS'(PROG_BITS - 1)) begin
            state           <= S_IDLE;
            done            <= 1'b1;
            nearest_index   <= 8'(best_idx);
            progress        <= quo_next;
            stored_count    <= 9'(point_count);
            table_empty     <= 1'b0;
            append_rejected <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // results only ever come out while the sequencer is idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe outside idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    point_count <= CNT_BITS'(MAX_POINTS))
    else $error("point count beyond table size");

  a_issue_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issue_idx <= point_count)
    else $error("scan address ran past the table");

  a_reject_full: assert property (@(posedge clk) disable iff (rst)
    done && append_rejected |-> point_count == CNT_BITS'(MAX_POINTS))
    else $error("append rejected with room in the table");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    done && table_empty |-> nearest_index == '0 && progress == '0)
    else $error("non-zero result from an empty table");

  a_accept_acts: assert property (@(posedge clk) disable iff (rst)
    accept |=> done || busy)
    else $error("accepted transaction produced nothing");

endmodule
